@@ sv/pfcadm_pkg.sv @@
package pfcadm_pkg;

  // Geometry of the per-queue account store.
  localparam int PORTS   = 64;
  localparam int QUEUES  = 8;
  localparam int ENTRIES = PORTS * QUEUES;
  localparam int ENTRY_W = $clog2(ENTRIES);

  // Field widths.
  localparam int CNT_W   = 26;
  localparam int SIZE_W  = 16;
  localparam int PORT_W  = 6;
  localparam int QUEUE_W = 3;
  localparam int BYTES_W = 20;
  localparam int ALPHA_W = 4;
  localparam int PCNT_W  = 7;
  localparam int CIDX_W  = 3;
  localparam int BASE_W  = 28;
  localparam int TAKEN_W = 29;

  localparam logic [CNT_W-1:0]   CNT_MAX      = {CNT_W{1'b1}};
  localparam logic [CNT_W-1:0]   TOTAL_RESET  = CNT_W'(12 * 1024 * 1024);
  localparam logic [BYTES_W-1:0] RSV_RESET    = BYTES_W'(4 * 1024);
  localparam logic [BYTES_W-1:0] MARGIN_RESET = BYTES_W'(3 * 1024);

  typedef enum logic [CIDX_W-1:0] {
    CFG_TOTAL   = 3'd0,
    CFG_RESERVE = 3'd1,
    CFG_MARGIN  = 3'd2,
    CFG_HDRM    = 3'd3,
    CFG_ALPHA   = 3'd4,
    CFG_PORTS   = 3'd5
  } cfg_idx_e;

  typedef enum logic {
    REQ_ARRIVAL   = 1'b0,
    REQ_DEPARTURE = 1'b1
  } req_kind_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_THR,
    ST_EVAL,
    ST_THR2,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic               req_type;
    logic [PORT_W-1:0]  port_index;
    logic [QUEUE_W-1:0] queue_index;
    logic [SIZE_W-1:0]  packet_bytes;
  } req_t;

  typedef struct packed {
    logic             admitted;
    logic             send_pause;
    logic             send_resume;
    logic [CNT_W-1:0] pfc_threshold;
  } rsp_t;

  typedef struct packed {
    logic [CIDX_W-1:0] index;
    logic [CNT_W-1:0]  wdata;
  } cfg_wr_t;

  // One stored account of a (port, queue) pair.
  typedef struct packed {
    logic             paused;
    logic [CNT_W-1:0] hdrm_used;
    logic [CNT_W-1:0] ingress;
  } entry_t;

  function automatic logic [CNT_W-1:0] sat_add(logic [CNT_W-1:0] a, logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CNT_W] ? CNT_MAX : s[CNT_W-1:0];
  endfunction

  function automatic logic [CNT_W-1:0] floor_sub(logic [CNT_W-1:0] a, logic [CNT_W-1:0] b);
    return (a > b) ? (a - b) : '0;
  endfunction

  function automatic logic [CNT_W-1:0] shared_of(logic [CNT_W-1:0] ing,
                                                 logic [BYTES_W-1:0] rsv);
    return floor_sub(ing, CNT_W'(rsv));
  endfunction

  // Free shared pool shifted right by alpha, clamped at zero.
  function automatic logic [CNT_W-1:0] threshold(logic [CNT_W-1:0]   total,
                                                 logic [BASE_W-1:0]  base,
                                                 logic [CNT_W-1:0]   shared,
                                                 logic [ALPHA_W-1:0] alpha);
    logic [TAKEN_W-1:0] taken;
    logic [CNT_W-1:0]   free_pool;
    taken     = TAKEN_W'(base) + TAKEN_W'(shared);
    free_pool = (TAKEN_W'(total) > taken) ? (total - taken[CNT_W-1:0]) : '0;
    return free_pool >> alpha;
  endfunction

  function automatic logic in_range(logic [PORT_W-1:0] port, logic [QUEUE_W-1:0] queue);
    return (int'(port) < PORTS) && (int'(queue) < QUEUES);
  endfunction

  function automatic logic [ENTRY_W-1:0] entry_of(logic [PORT_W-1:0]  port,
                                                  logic [QUEUE_W-1:0] queue);
    return ENTRY_W'(int'(port) * QUEUES + int'(queue));
  endfunction

endpackage

@@ sv/pfcadm_if.sv @@
interface pfcadm_req_if;
  import pfcadm_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pfcadm_rsp_if;
  import pfcadm_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pfcadm_cfg_if;
  import pfcadm_pkg::*;
  logic    valid;
  logic    ready;
  cfg_wr_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ sv/pfc_ingress_buffer_admission_unit.sv @@
// Channel | Direction | Payload                                          | Moves
// req_i   | in        | req_type, port_index, queue_index, packet_bytes  | one request
// rsp_o   | out       | admitted, send_pause, send_resume, pfc_threshold | one result
// cfg_i   | in        | index (register number), wdata                  | one register write
//
// An accepted request passes four steps in order (threshold, charge or refund,
// threshold after the charge, pause/resume decision with write-back); the next request
// is taken in the idle state after that, so none starts before the last is done.
// After reset a clearing pass zeroes all 512 accounts; requests wait until it is done,
// while configuration writes are taken. A result still waiting in the output register
// holds the final step, and no new request enters until it has left.
module pfc_ingress_buffer_admission_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  pfcadm_req_if.sink          req_i,
  pfcadm_rsp_if.source        rsp_o,
  pfcadm_cfg_if.sink          cfg_i
);
  import pfcadm_pkg::*;

  // Configuration registers.
  logic [CNT_W-1:0]   total_q;
  logic [BYTES_W-1:0] rsv_q;
  logic [BYTES_W-1:0] margin_q;
  logic [BYTES_W-1:0] hdrm_q;
  logic [ALPHA_W-1:0] alpha_q;
  logic [PCNT_W-1:0]  pcnt_q;

  // Headroom and reserve taken out of the buffer for all active ports. Kept in a
  // register, which a configuration write reaches before any threshold uses it.
  logic [BASE_W-1:0]  base_q;

  logic [CNT_W-1:0]   shared_q;
  logic [CNT_W-1:0]   thr_q;

  state_e             state_q, state_d;
  logic [ENTRY_W-1:0] clr_q;

  // The request in flight.
  req_t               req_q;
  logic [ENTRY_W-1:0] idx_q;
  logic               valid_idx_q;
  entry_t             rd_q;

  // Results of the charge/refund step.
  logic [CNT_W-1:0]   ing_n_q;
  logic [CNT_W-1:0]   hdr_n_q;
  logic               adm_q;
  logic               upd_q;

  logic               rsp_valid_q;
  rsp_t               rsp_q;

  // Account memory.
  entry_t             mem [ENTRIES];
  logic               mem_we;
  logic [ENTRY_W-1:0] mem_waddr;
  entry_t             mem_wdata;

  logic               req_acc;
  logic               cfg_acc;
  logic               rsp_load;

  assign req_acc = req_i.valid & req_i.ready;
  assign cfg_acc = cfg_i.valid & cfg_i.ready;

  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.data  = rsp_q;

  // ---------------------------------------------------------------------------
  // Configuration. Unknown register numbers are dropped.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q  <= TOTAL_RESET;
      rsv_q    <= RSV_RESET;
      margin_q <= MARGIN_RESET;
      hdrm_q   <= '0;
      alpha_q  <= '0;
      pcnt_q   <= '0;
    end else if (cfg_acc) begin
      unique case (cfg_i.data.index)
        CFG_TOTAL:   total_q  <= cfg_i.data.wdata;
        CFG_RESERVE: rsv_q    <= cfg_i.data.wdata[BYTES_W-1:0];
        CFG_MARGIN:  margin_q <= cfg_i.data.wdata[BYTES_W-1:0];
        CFG_HDRM:    hdrm_q   <= cfg_i.data.wdata[BYTES_W-1:0];
        CFG_ALPHA:   alpha_q  <= cfg_i.data.wdata[ALPHA_W-1:0];
        CFG_PORTS:   pcnt_q   <= cfg_i.data.wdata[PCNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
    end else begin
      base_q <= BASE_W'(pcnt_q) * BASE_W'(hdrm_q) + BASE_W'(pcnt_q) * BASE_W'(rsv_q);
    end
  end

  // ---------------------------------------------------------------------------
  // Charge on arrival, refund on departure.
  // ---------------------------------------------------------------------------
  logic [CNT_W-1:0]  ev_ing, ev_hdr, ev_shared, ev_sh;
  logic              ev_adm, ev_upd;
  logic [CNT_W:0]    ev_nb, ev_part;
  logic              over_hdrm, over_thr;
  logic [SIZE_W-1:0] take_s, from_h, rest, from_s;

  always_comb begin
    ev_ing    = rd_q.ingress;
    ev_hdr    = rd_q.hdrm_used;
    ev_shared = shared_q;
    ev_sh     = shared_of(rd_q.ingress, rsv_q);
    ev_adm    = (req_q.req_type == REQ_DEPARTURE);
    ev_upd    = 1'b0;
    ev_nb     = {1'b0, rd_q.ingress} + (CNT_W+1)'(req_q.packet_bytes);
    ev_part   = ev_nb - (CNT_W+1)'(rsv_q);
    over_hdrm = ({1'b0, rd_q.hdrm_used} + (CNT_W+1)'(req_q.packet_bytes))
                > (CNT_W+1)'(hdrm_q);
    over_thr  = ({1'b0, ev_sh} + (CNT_W+1)'(req_q.packet_bytes)) > {1'b0, thr_q};
    take_s    = (ev_part < (CNT_W+1)'(req_q.packet_bytes)) ? ev_part[SIZE_W-1:0]
                                                            : req_q.packet_bytes;
    from_h    = (rd_q.hdrm_used < CNT_W'(req_q.packet_bytes)) ? rd_q.hdrm_used[SIZE_W-1:0]
                                                               : req_q.packet_bytes;
    rest      = req_q.packet_bytes - from_h;
    from_s    = (CNT_W'(rest) < ev_sh) ? rest : ev_sh[SIZE_W-1:0];

    if (valid_idx_q) begin
      if (req_q.req_type == REQ_ARRIVAL) begin
        if (!(over_hdrm && over_thr)) begin
          ev_adm = 1'b1;
          ev_upd = 1'b1;
          if (ev_nb <= (CNT_W+1)'(rsv_q)) begin
            ev_ing = sat_add(rd_q.ingress, CNT_W'(req_q.packet_bytes));
          end else if (ev_part > {1'b0, thr_q}) begin
            ev_hdr = sat_add(rd_q.hdrm_used, CNT_W'(req_q.packet_bytes));
          end else begin
            ev_ing    = sat_add(rd_q.ingress, CNT_W'(req_q.packet_bytes));
            ev_shared = sat_add(shared_q, CNT_W'(take_s));
          end
        end
      end else begin
        ev_upd    = 1'b1;
        ev_hdr    = rd_q.hdrm_used - CNT_W'(from_h);
        ev_ing    = floor_sub(rd_q.ingress, CNT_W'(rest));
        ev_shared = floor_sub(shared_q, CNT_W'(from_s));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Pause and resume decision against the threshold after the charge.
  // ---------------------------------------------------------------------------
  logic [CNT_W-1:0] fin_su;
  logic             fin_pause, fin_resume;

  always_comb begin
    fin_su     = shared_of(ing_n_q, rsv_q);
    fin_pause  = 1'b0;
    fin_resume = 1'b0;
    if (upd_q) begin
      if (req_q.req_type == REQ_ARRIVAL) begin
        fin_pause = !rd_q.paused && ((hdr_n_q != '0) || (fin_su >= thr_q));
      end else begin
        fin_resume = rd_q.paused && (hdr_n_q == '0) &&
                     ((fin_su == '0) ||
                      (({1'b0, fin_su} + (CNT_W+1)'(margin_q)) <= {1'b0, thr_q}));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    req_i.ready = 1'b0;
    cfg_i.ready = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = idx_q;
    mem_wdata   = '{paused: rd_q.paused ^ fin_pause ^ fin_resume,
                    hdrm_used: hdr_n_q, ingress: ing_n_q};
    rsp_load    = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        cfg_i.ready = 1'b1;
        mem_we      = 1'b1;
        mem_waddr   = clr_q;
        mem_wdata   = '0;
        if (clr_q == ENTRY_W'(ENTRIES - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        cfg_i.ready = 1'b1;
        // A configuration write goes first so that both never land on one edge.
        req_i.ready = !cfg_i.valid;
        if (req_acc) begin
          state_d = ST_THR;
        end
      end
      ST_THR: begin
        state_d = ST_EVAL;
      end
      ST_EVAL: begin
        state_d = ST_THR2;
      end
      ST_THR2: begin
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          rsp_load = 1'b1;
          mem_we   = upd_q;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (state_q == ST_CLEAR) begin
      clr_q <= clr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shared_q <= '0;
    end else if (state_q == ST_EVAL) begin
      shared_q <= ev_shared;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      req_q       <= req_i.data;
      idx_q       <= entry_of(req_i.data.port_index, req_i.data.queue_index);
      valid_idx_q <= in_range(req_i.data.port_index, req_i.data.queue_index);
    end
    if (state_q == ST_THR || state_q == ST_THR2) begin
      thr_q <= threshold(total_q, base_q, shared_q, alpha_q);
    end
    if (state_q == ST_EVAL) begin
      ing_n_q <= ev_ing;
      hdr_n_q <= ev_hdr;
      adm_q   <= ev_adm;
      upd_q   <= ev_upd;
    end
  end

  // Single-port account memory; the write-back always lands before the next read.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (req_acc) begin
      rd_q <= mem[entry_of(req_i.data.port_index, req_i.data.queue_index)];
    end
  end

  // ---------------------------------------------------------------------------
  // Output register.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rsp_load) begin
      rsp_q <= '{admitted: adm_q, send_pause: fin_pause, send_resume: fin_resume,
                 pfc_threshold: thr_q};
    end
  end

endmodule

@@ test/pfcadm_admission_monitor.sv @@
module pfcadm_admission_monitor
  import pfcadm_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    req_valid_i,
  input  logic    req_ready_i,
  input  req_t    req_data_i,
  input  logic    rsp_valid_i,
  input  logic    rsp_ready_i,
  input  rsp_t    rsp_data_i,
  input  logic    cfg_valid_i,
  input  logic    cfg_ready_i,
  input  cfg_wr_t cfg_data_i,
  output int      pending_o,
  output int      errors_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Register copies, kept at the widths of the block.
  logic [CNT_W-1:0]   cfg_total;
  logic [BYTES_W-1:0] cfg_rsv;
  logic [BYTES_W-1:0] cfg_margin;
  logic [BYTES_W-1:0] cfg_hdrm;
  logic [ALPHA_W-1:0] cfg_alpha;
  logic [PCNT_W-1:0]  cfg_ports;

  // Per-queue accounts and the shared pool counter.
  logic [CNT_W-1:0] acct_ingress [ENTRIES];
  logic [CNT_W-1:0] acct_hdrm    [ENTRIES];
  bit               acct_paused  [ENTRIES];
  logic [CNT_W-1:0] pool_used;

  rsp_t predicted_verdicts[$];
  int   mismatch_total;

  function automatic longint unsigned add_clamped(longint unsigned a, longint unsigned b);
    longint unsigned s;
    s = a + b;
    return (s > 64'(CNT_MAX)) ? 64'(CNT_MAX) : s;
  endfunction

  function automatic longint unsigned over_reserve(longint unsigned ing);
    longint unsigned rsv;
    rsv = 64'(cfg_rsv);
    return (ing > rsv) ? ing - rsv : 64'd0;
  endfunction

  // Free shared space shifted right by alpha; zero once the pool is overcommitted.
  function automatic longint unsigned shared_limit();
    longint unsigned taken;
    longint unsigned total;
    taken = 64'(cfg_ports) * 64'(cfg_hdrm) + 64'(cfg_ports) * 64'(cfg_rsv)
            + 64'(pool_used);
    total = 64'(cfg_total);
    return (total > taken) ? (total - taken) >> cfg_alpha : 64'd0;
  endfunction

  // Applies one request to the accounts and returns the verdict it must produce.
  function automatic rsp_t charge_or_refund(req_t r);
    rsp_t            v;
    int              e;
    longint unsigned ing, hdr, sz, nb, part, thr, take_h, rest, take_s, su;
    v          = '0;
    v.admitted = (r.req_type == REQ_DEPARTURE);
    if (int'(r.port_index) < PORTS && int'(r.queue_index) < QUEUES) begin
      e   = int'(r.port_index) * QUEUES + int'(r.queue_index);
      ing = 64'(acct_ingress[e]);
      hdr = 64'(acct_hdrm[e]);
      sz  = 64'(r.packet_bytes);
      if (r.req_type == REQ_ARRIVAL) begin
        thr = shared_limit();
        // Dropped only when neither headroom nor the shared threshold can take it.
        if (!((sz + hdr > 64'(cfg_hdrm)) && (sz + over_reserve(ing) > thr))) begin
          v.admitted = 1'b1;
          nb         = ing + sz;
          if (nb <= 64'(cfg_rsv)) begin
            acct_ingress[e] = CNT_W'(add_clamped(ing, sz));
          end else if (nb - 64'(cfg_rsv) > thr) begin
            acct_hdrm[e] = CNT_W'(add_clamped(hdr, sz));
          end else begin
            part            = nb - 64'(cfg_rsv);
            acct_ingress[e] = CNT_W'(add_clamped(ing, sz));
            pool_used       = CNT_W'(add_clamped(64'(pool_used), (sz < part) ? sz : part));
          end
          if (!acct_paused[e] && (acct_hdrm[e] != '0 ||
              over_reserve(64'(acct_ingress[e])) >= shared_limit())) begin
            acct_paused[e] = 1'b1;
            v.send_pause   = 1'b1;
          end
        end
      end else begin
        // Refund headroom first, then the queue's own bytes; the pool gets back
        // only what lay above the reserve.
        take_h          = (hdr < sz) ? hdr : sz;
        rest            = sz - take_h;
        take_s          = (rest < over_reserve(ing)) ? rest : over_reserve(ing);
        acct_hdrm[e]    = CNT_W'(hdr - take_h);
        acct_ingress[e] = CNT_W'((ing > rest) ? ing - rest : 64'd0);
        pool_used       = CNT_W'((64'(pool_used) > take_s) ? 64'(pool_used) - take_s : 64'd0);
        if (acct_paused[e] && acct_hdrm[e] == '0) begin
          su = over_reserve(64'(acct_ingress[e]));
          if (su == 64'd0 || su + 64'(cfg_margin) <= shared_limit()) begin
            acct_paused[e] = 1'b0;
            v.send_resume  = 1'b1;
          end
        end
      end
    end
    v.pfc_threshold = CNT_W'(shared_limit());
    return v;
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatch_total++;
  endtask

  task automatic compare_field(string name, longint unsigned got, longint unsigned want);
    if (got != want) begin
      report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    if (!rst_ni) begin
      cfg_total  = TOTAL_RESET;
      cfg_rsv    = RSV_RESET;
      cfg_margin = MARGIN_RESET;
      cfg_hdrm   = '0;
      cfg_alpha  = '0;
      cfg_ports  = '0;
      for (int i = 0; i < ENTRIES; i++) begin
        acct_ingress[i] = '0;
        acct_hdrm[i]    = '0;
        acct_paused[i]  = 1'b0;
      end
      pool_used = '0;
      predicted_verdicts.delete();
      mismatch_total = 0;
      pending_o <= 0;
      errors_o  <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        unique case (cfg_idx_e'(cfg_data_i.index))
          CFG_TOTAL:   cfg_total  = cfg_data_i.wdata;
          CFG_RESERVE: cfg_rsv    = cfg_data_i.wdata[BYTES_W-1:0];
          CFG_MARGIN:  cfg_margin = cfg_data_i.wdata[BYTES_W-1:0];
          CFG_HDRM:    cfg_hdrm   = cfg_data_i.wdata[BYTES_W-1:0];
          CFG_ALPHA:   cfg_alpha  = cfg_data_i.wdata[ALPHA_W-1:0];
          CFG_PORTS:   cfg_ports  = cfg_data_i.wdata[PCNT_W-1:0];
          default: ;
        endcase
      end
      if (rsp_valid_i && rsp_ready_i) begin
        if (predicted_verdicts.size() == 0) begin
          report_mismatch("result with no request outstanding");
        end else begin
          want = predicted_verdicts.pop_front();
          compare_field("admitted", 64'(rsp_data_i.admitted), 64'(want.admitted));
          compare_field("send_pause", 64'(rsp_data_i.send_pause), 64'(want.send_pause));
          compare_field("send_resume", 64'(rsp_data_i.send_resume),
                        64'(want.send_resume));
          compare_field("pfc_threshold", 64'(rsp_data_i.pfc_threshold),
                        64'(want.pfc_threshold));
        end
      end
      if (req_valid_i && req_ready_i) begin
        predicted_verdicts.insert(predicted_verdicts.size(), charge_or_refund(req_data_i));
      end
      pending_o <= predicted_verdicts.size();
      errors_o  <= mismatch_total;
    end
  end

endmodule

@@ test/pfc_ingress_buffer_admission_unit_tb.sv @@
module pfc_ingress_buffer_admission_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pfcadm_pkg::*;

  // One full set of admission registers, written as a group while the block is idle.
  typedef struct packed {
    logic [CNT_W-1:0]   total;
    logic [BYTES_W-1:0] rsv;
    logic [BYTES_W-1:0] margin;
    logic [BYTES_W-1:0] hdrm;
    logic [ALPHA_W-1:0] alpha;
    logic [PCNT_W-1:0]  ports;
  } setting_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  // Percent of cycles in which the sender holds back and the receiver stalls.
  int send_idle_pct = 0;
  int stall_pct     = 0;

  int pending;
  int errors;

  // Hot queues of the current random phase; most traffic lands on them so
  // that accounts grow far enough to pause, drop and resume.
  int hot_port  [3];
  int hot_queue [3];

  setting_t phase_setting [7];
  int       phase_items   [7];

  pfcadm_req_if req_if ();
  pfcadm_rsp_if rsp_if ();
  pfcadm_cfg_if cfg_if ();

  pfc_ingress_buffer_admission_unit DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .cfg_i  (cfg_if)
  );

  pfcadm_admission_monitor u_monitor (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_if.valid),
    .req_ready_i (req_if.ready),
    .req_data_i  (req_if.data),
    .rsp_valid_i (rsp_if.valid),
    .rsp_ready_i (rsp_if.ready),
    .rsp_data_i  (rsp_if.data),
    .cfg_valid_i (cfg_if.valid),
    .cfg_ready_i (cfg_if.ready),
    .cfg_data_i  (cfg_if.data),
    .pending_o   (pending),
    .errors_o    (errors)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // The result side stalls at random, at the rate set by the current phase.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Hard stop in case the block hangs; the slowest legal run needs well under
  // a tenth of this.
  initial begin
    #2ms;
    $display("TEST FAILED");
    $finish;
  end

  // The idling profiles: none, sender mostly idle, receiver mostly stalled,
  // and both occasionally idle.
  task automatic set_idling(int mode);
    unique case (mode)
      0: begin
        send_idle_pct = 0;
        stall_pct     = 0;
      end
      1: begin
        send_idle_pct = 87;
        stall_pct     = 0;
      end
      2: begin
        send_idle_pct = 0;
        stall_pct     = 87;
      end
      default: begin
        send_idle_pct = 9;
        stall_pct     = 9;
      end
    endcase
  endtask

  // Presents one request and returns at the edge that accepts it. Valid stays
  // high into the next request unless a gap is drawn, so it is never lowered and
  // raised within one step.
  task automatic offer_request(req_kind_e kind, int port, int queue, int bytes);
    req_t r;
    int   gap;
    r.req_type    = kind;
    r.port_index  = PORT_W'(port);
    r.queue_index = QUEUE_W'(queue);
    r.packet_bytes = SIZE_W'(bytes);
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= r;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  task automatic write_register(cfg_idx_e idx, logic [CNT_W-1:0] value);
    cfg_if.valid      <= 1'b1;
    cfg_if.data.index <= idx;
    cfg_if.data.wdata <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
  endtask

  task automatic apply_setting(setting_t s);
    write_register(CFG_TOTAL, s.total);
    write_register(CFG_RESERVE, CNT_W'(s.rsv));
    write_register(CFG_MARGIN, CNT_W'(s.margin));
    write_register(CFG_HDRM, CNT_W'(s.hdrm));
    write_register(CFG_ALPHA, CNT_W'(s.alpha));
    write_register(CFG_PORTS, CNT_W'(s.ports));
    cfg_if.valid <= 1'b0;
  endtask

  // Holds the sender until every predicted verdict has been seen, then lets the
  // block and the account write-back settle before anything else moves.
  task automatic wait_drained();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (10) @(posedge clk_i);
  endtask

  // Random traffic: mostly arrivals and departures on a few hot queues, with a
  // share of fully random requests that sweep every port, queue and size bit.
  task automatic random_traffic(int count);
    int pick;
    int bytes;
    for (int i = 0; i < 3; i++) begin
      hot_port[i]  = $urandom_range(63);
      hot_queue[i] = $urandom_range(7);
    end
    for (int k = 0; k < count; k++) begin
      // Halfway through, the sender waits for the pipe to empty completely.
      if (k == count / 2) wait_drained();
      if ($urandom_range(99) < 80) begin
        pick  = $urandom_range(2);
        bytes = ($urandom_range(1) != 0) ? $urandom_range(1, 16384)
                                         : $urandom_range(16384, 65535);
        offer_request(($urandom_range(99) < 55) ? REQ_ARRIVAL : REQ_DEPARTURE,
                      hot_port[pick], hot_queue[pick], bytes);
      end else begin
        case ($urandom_range(3))
          0:       bytes = 0;
          1:       bytes = 65535;
          default: bytes = $urandom_range(65535);
        endcase
        offer_request(($urandom_range(1) != 0) ? REQ_DEPARTURE : REQ_ARRIVAL,
                      $urandom_range(63), $urandom_range(7), bytes);
      end
    end
  endtask

  initial begin
    setting_t s;

    rst_ni           <= 1'b0;
    req_if.valid     <= 1'b0;
    req_if.data      <= '0;
    cfg_if.valid     <= 1'b0;
    cfg_if.data      <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Random phase settings, from a generous pool to a fully overcommitted one;
    // each register but the port count (0 to 64) reaches both of its ends.
    phase_setting[0] = '{total: 400000,   rsv: 4096,    margin: 3072,
                         hdrm: 60000,     alpha: 1,     ports: 2};
    phase_setting[1] = '{total: 67108863, rsv: 0,       margin: 0,
                         hdrm: 1048575,   alpha: 0,     ports: 64};
    phase_setting[2] = '{total: 0,        rsv: 1048575, margin: 1048575,
                         hdrm: 0,         alpha: 15,    ports: 0};
    phase_setting[3] = '{total: 200000,   rsv: 16384,   margin: 1048575,
                         hdrm: 30000,     alpha: 0,     ports: 1};
    phase_setting[4] = '{total: 67108863, rsv: 65536,   margin: 2048,
                         hdrm: 131072,    alpha: 15,    ports: 64};
    phase_setting[5] = '{total: 12582912, rsv: 4096,    margin: 3072,
                         hdrm: 0,         alpha: 0,     ports: 0};
    phase_setting[6] = '{total:  CNT_W'($urandom_range(2000000)),
                         rsv:    BYTES_W'($urandom_range(70000)),
                         margin: BYTES_W'($urandom_range(70000)),
                         hdrm:   BYTES_W'($urandom_range(200000)),
                         alpha:  ALPHA_W'($urandom_range(15)),
                         ports:  PCNT_W'($urandom_range(64))};
    phase_items = '{200, 150, 60, 200, 120, 80, 120};

    set_idling(0);

    // Reset values: zero-byte and full-size requests at the corner queues, and
    // a departure from an empty account that must stop at zero.
    offer_request(REQ_ARRIVAL, 0, 0, 0);
    offer_request(REQ_ARRIVAL, 63, 7, 65535);
    offer_request(REQ_DEPARTURE, 63, 7, 65535);
    offer_request(REQ_DEPARTURE, 0, 0, 65535);
    wait_drained();

    // A small buffer with one port: the shared threshold starts at 25904 bytes
    // and headroom holds 70000. One queue walks through reserve, shared pool,
    // pause, headroom, a drop when both are full, and a resume once it drains.
    s = '{total: 100000, rsv: 4096, margin: 3072, hdrm: 70000, alpha: 0, ports: 1};
    apply_setting(s);
    offer_request(REQ_ARRIVAL, 5, 3, 4096);
    offer_request(REQ_ARRIVAL, 5, 3, 20000);
    offer_request(REQ_ARRIVAL, 5, 3, 30000);
    offer_request(REQ_ARRIVAL, 5, 3, 50000);
    offer_request(REQ_DEPARTURE, 5, 3, 10000);
    offer_request(REQ_DEPARTURE, 5, 3, 30000);
    offer_request(REQ_ARRIVAL, 1, 2, 65535);
    offer_request(REQ_DEPARTURE, 5, 3, 65535);
    offer_request(REQ_DEPARTURE, 1, 2, 65535);
    wait_drained();

    // Reserve and headroom of all 64 ports exceed the buffer, so the free pool
    // would go negative and the threshold must sit at zero.
    s = '{total: 100000, rsv: 1048575, margin: 0, hdrm: 65535, alpha: 0, ports: 64};
    apply_setting(s);
    offer_request(REQ_ARRIVAL, 2, 1, 65535);
    offer_request(REQ_ARRIVAL, 2, 1, 1);
    offer_request(REQ_DEPARTURE, 2, 1, 65535);
    offer_request(REQ_DEPARTURE, 2, 1, 65535);
    wait_drained();

    // Random phases, each under its own setting and one of the idling profiles.
    for (int p = 0; p < 7; p++) begin
      apply_setting(phase_setting[p]);
      set_idling(p % 4);
      random_traffic(phase_items[p]);
      wait_drained();
    end

    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ pfc_ingress_buffer_admission_unit.f @@
sv/pfcadm_pkg.sv
sv/pfcadm_if.sv
sv/pfc_ingress_buffer_admission_unit.sv
test/pfcadm_admission_monitor.sv
test/pfc_ingress_buffer_admission_unit_tb.sv
